>>> hw/rtl/splat_attribute_decoder_core_assert.svh
// assertion macros shared by the decoder rtl
`ifndef SPLAT_ATTRIBUTE_DECODER_CORE_ASSERT_SVH
`define SPLAT_ATTRIBUTE_DECODER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SAD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SAD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/sad_pkg.sv
// types, constants and tables of the splat attribute decoder
package sad_pkg;

    localparam int MAG_BITS   = 15;
    localparam int NUM_STAGES = MAG_BITS + 3;
    localparam int SCALE_DONE = 4;

    localparam logic [20:0] DC_GAIN_Q16 = 21'd1865841;
    localparam logic [63:0] LN2_Q30     = 64'd744261118;
    localparam logic [21:0] QUAT_R2     = 22'd2093058;
    localparam logic signed [15:0] LOGIT_CLAMP = 16'sd28290;

    typedef logic [0:0] cfg_idx_t;
    localparam cfg_idx_t REG_SCALE_MIN = 1'd0;
    localparam cfg_idx_t REG_SCALE_MAX = 1'd1;

    localparam logic [1:0] QUAT_PLACE [4][4] = '{
        '{2'd3, 2'd0, 2'd1, 2'd2},
        '{2'd0, 2'd3, 2'd1, 2'd2},
        '{2'd0, 2'd1, 2'd3, 2'd2},
        '{2'd0, 2'd1, 2'd2, 2'd3}
    };

    typedef struct packed {
        logic                   neg;
        logic [21:0]            p;
        logic [MAG_BITS-1:0]    m;
        logic signed [57:0]     a;
        logic signed [57:0]     b;
    } root_comp_t;

    typedef struct packed {
        root_comp_t [3:0]       comp;
        logic [21:0]            l2;
        logic [1:0]             mode;
    } root_t;

    typedef struct packed {
        logic signed [15:0]     dc_r;
        logic signed [15:0]     dc_g;
        logic signed [15:0]     dc_b;
        logic signed [15:0]     logit;
        logic signed [31:0]     scale_x;
        logic signed [31:0]     scale_y;
        logic signed [31:0]     scale_z;
    } side_t;

    typedef logic signed [15:0] logit_tab_t [256];

    function automatic logic signed [15:0] color_dc(input logic [7:0] c);
        logic signed [9:0] d;
        logic [7:0]        m;
        logic [28:0]       prod;
        logic [12:0]       r;
        d    = $signed({1'b0, c, 1'b0}) - 10'sd255;
        m    = d[9] ? 8'(-d) : d[7:0];
        prod = 29'(m) * 29'(DC_GAIN_Q16) + 29'd32768;
        r    = prod[28:16];
        return d[9] ? -$signed({3'b0, r}) : $signed({3'b0, r});
    endfunction

    function automatic logic [31:0] log2_q24(input logic [7:0] n);
        logic [2:0]  k;
        logic [63:0] x;
        logic [23:0] frac;
        k    = 3'd0;
        frac = 24'd0;
        for (int j = 1; j < 8; j++)
        begin
            if ((n >> j) != 8'd0)
                k = 3'(j);
        end
        x = {56'd0, n} << (30 - int'(k));
        for (int i = 0; i < 24; i++)
        begin
            x    = (x * x) >> 30;
            frac = {frac[22:0], 1'b0};
            if (x >= 64'h8000_0000)
            begin
                x       = x >> 1;
                frac[0] = 1'b1;
            end
        end
        return {5'd0, k, frac};
    endfunction

    function automatic logit_tab_t build_logit_tab();
        logit_tab_t  t;
        logic [31:0] la;
        logic [31:0] lb;
        logic [31:0] mag;
        logic [63:0] r;
        for (int a = 0; a < 256; a++)
        begin
            if (a == 0)
                t[a] = -LOGIT_CLAMP;
            else if (a == 255)
                t[a] = LOGIT_CLAMP;
            else
            begin
                la  = log2_q24(8'(a));
                lb  = log2_q24(8'(255 - a));
                mag = (la < lb) ? lb - la : la - lb;
                r   = (64'(mag) * LN2_Q30 + (64'd1 << 41)) >> 42;
                t[a] = (la < lb) ? -$signed(r[15:0]) : $signed(r[15:0]);
            end
        end
        return t;
    endfunction

    localparam logit_tab_t LOGIT_TAB = build_logit_tab();

endpackage

>>> hw/rtl/sad_if.sv
// valid/ready channels for splat records and decoded results
interface sad_rec_if;
    logic        valid;
    logic        ready;
    logic [31:0] color_word;
    logic [15:0] scale_code_x;
    logic [15:0] scale_code_y;
    logic [15:0] scale_code_z;
    logic [31:0] rotation_word;

    modport source (output valid, color_word, scale_code_x, scale_code_y, scale_code_z,
                    rotation_word, input ready);
    modport sink (input valid, color_word, scale_code_x, scale_code_y, scale_code_z,
                  rotation_word, output ready);
endinterface

interface sad_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] dc_red;
    logic signed [15:0] dc_green;
    logic signed [15:0] dc_blue;
    logic signed [15:0] opacity_logit;
    logic signed [31:0] scale_out_x;
    logic signed [31:0] scale_out_y;
    logic signed [31:0] scale_out_z;
    logic signed [15:0] quat_first;
    logic signed [15:0] quat_second;
    logic signed [15:0] quat_third;
    logic signed [15:0] quat_fourth;

    modport source (output valid, dc_red, dc_green, dc_blue, opacity_logit, scale_out_x,
                    scale_out_y, scale_out_z, quat_first, quat_second, quat_third,
                    quat_fourth, input ready);
    modport sink (input valid, dc_red, dc_green, dc_blue, opacity_logit, scale_out_x,
                  scale_out_y, scale_out_z, quat_first, quat_second, quat_third,
                  quat_fourth, output ready);
endinterface

>>> hw/rtl/sad_scale_lane.sv
// four-stage scale interpolation lane with divide by 65535 and saturation
module sad_scale_lane (
    input  logic               clk,
    input  logic [3:0]         load,
    input  logic [15:0]        code,
    input  logic signed [31:0] lo,
    input  logic signed [31:0] hi,
    output logic signed [31:0] scale
);
    import sad_pkg::*;

    logic signed [32:0] diff;
    logic signed [16:0] code_s;
    logic signed [49:0] prod_next;
    logic signed [49:0] prod_reg;

    logic               neg1_next;
    logic [48:0]        mag1;
    logic [48:0]        n1_next;
    logic [49:0]        est1;
    logic [48:0]        n1_reg;
    logic [33:0]        q1_reg;
    logic               neg1_reg;

    logic [49:0]        rem2;
    logic [33:0]        q2_next;
    logic [33:0]        q2_reg;
    logic               neg2_reg;

    logic signed [34:0] qs3;
    logic signed [34:0] sum3;
    logic signed [31:0] scale_next;
    logic signed [31:0] scale_reg;

    always_comb
    begin
        diff      = $signed({hi[31], hi}) - $signed({lo[31], lo});
        code_s    = $signed({1'b0, code});
        prod_next = code_s * diff;
    end

    always_comb
    begin
        neg1_next = prod_reg[49];
        mag1      = 49'(neg1_next ? -prod_reg : prod_reg);
        n1_next   = mag1 + 49'd32767;
        est1      = 50'(n1_next) + 50'(n1_next >> 16) + 50'(n1_next >> 32);
    end

    always_comb
    begin
        rem2    = 50'(n1_reg) - (50'(q1_reg) << 16) + 50'(q1_reg);
        q2_next = (rem2 >= 50'd65535) ? q1_reg + 34'd1 : q1_reg;
    end

    always_comb
    begin
        qs3  = $signed({1'b0, q2_reg});
        sum3 = $signed({{3{lo[31]}}, lo}) + (neg2_reg ? -qs3 : qs3);
        if (sum3 > 35'sd2147483647)
            scale_next = 32'sh7FFF_FFFF;
        else if (sum3 < -35'sd2147483648)
            scale_next = 32'sh8000_0000;
        else
            scale_next = sum3[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
            prod_reg <= prod_next;
        if (load[1])
        begin
            n1_reg   <= n1_next;
            q1_reg   <= est1[49:16];
            neg1_reg <= neg1_next;
        end
        if (load[2])
        begin
            q2_reg   <= q2_next;
            neg2_reg <= neg1_reg;
        end
        if (load[3])
            scale_reg <= scale_next;
    end

    assign scale = scale_reg;

endmodule

>>> hw/rtl/sad_root_step.sv
// one bit of the quaternion magnitude search for all four components
module sad_root_step #(
    parameter int BIT = 14
) (
    input  logic           clk,
    input  logic           load,
    input  sad_pkg::root_t root_in,
    output sad_pkg::root_t root_out
);
    import sad_pkg::*;

    root_t              root_next;
    root_t              root_reg;
    logic signed [57:0] l2x;
    logic signed [57:0] cand [4];
    logic signed [57:0] limit [4];
    logic               guard [4];

    always_comb
    begin
        root_next = root_in;
        l2x       = $signed({36'd0, root_in.l2});
        for (int i = 0; i < 4; i++)
        begin
            guard[i] = (BIT != MAG_BITS - 1) && root_in.comp[i].m[MAG_BITS-1];
            cand[i]  = root_in.comp[i].a + (root_in.comp[i].b <<< (BIT + 2))
                     + (l2x <<< (2 * BIT + 2));
            limit[i] = $signed({6'd0, root_in.comp[i].p, 30'd0});
            if (!guard[i] && cand[i] <= limit[i])
            begin
                root_next.comp[i].m = root_in.comp[i].m | (MAG_BITS'(1) << BIT);
                root_next.comp[i].a = cand[i];
                root_next.comp[i].b = root_in.comp[i].b + (l2x <<< (BIT + 1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            root_reg <= root_next;
    end

    assign root_out = root_reg;

endmodule

>>> hw/rtl/splat_attribute_decoder_core.sv
// top level of the splat attribute decoder
// throughput: one record per cycle while the output channel is ready;
// the 15-step quaternion magnitude search is fully pipelined
// each stage holds its own valid bit, so a stalled output only stops the stages behind it
// reset clears all valid bits and loads scale_min = 168 and scale_max = 83886080
`include "splat_attribute_decoder_core_assert.svh"
module splat_attribute_decoder_core (
    input  logic              clk,
    input  logic              rst_n,
    sad_rec_if.sink           record,
    sad_res_if.source         result,
    input  logic              cfg_we,
    input  sad_pkg::cfg_idx_t cfg_index,
    input  logic [31:0]       cfg_data
);
    import sad_pkg::*;

    localparam int NST = NUM_STAGES;

    logic signed [31:0] scale_min_reg;
    logic signed [31:0] scale_max_reg;

    logic [NST-1:0]     vld_reg;
    logic [NST-1:0]     vld_next;
    logic [NST:0]       rdy;
    logic [NST-1:0]     load;

    side_t              side_next [NST];
    side_t              side_reg  [NST];
    logic signed [31:0] lane_scale [3];

    logic signed [10:0] v0_next [3];
    logic [19:0]        sq0_next [3];
    logic signed [10:0] v0_reg [3];
    logic [19:0]        sq0_reg [3];
    logic [1:0]         mode0_reg;

    logic [21:0]        s1;
    logic [21:0]        w2_1;
    logic [21:0]        l2_1;
    root_t              root1_next;
    root_t              root1_reg;
    root_t              root_pipe [MAG_BITS];

    logic [1:0]         sel_out [4];
    logic signed [15:0] mag_out [4];
    logic signed [15:0] quat_next [4];
    logic signed [15:0] quat_reg [4];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_min_reg <= 32'sd168;
            scale_max_reg <= 32'sd83886080;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCALE_MIN: scale_min_reg <= cfg_data;
                REG_SCALE_MAX: scale_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage handshake
    always_comb
    begin
        rdy[NST] = result.ready;
        for (int k = NST - 1; k >= 0; k--)
            rdy[k] = !vld_reg[k] || rdy[k+1];
        for (int k = 0; k < NST; k++)
        begin
            vld_next[k] = (k == 0) ? record.valid : vld_reg[k-1];
            load[k]     = rdy[k] && vld_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (rdy[k])
                    vld_reg[k] <= vld_next[k];
            end
        end
    end

    assign record.ready = rdy[0];

    // color, opacity and scale side path
    always_comb
    begin
        side_next[0].dc_r    = color_dc(record.color_word[7:0]);
        side_next[0].dc_g    = color_dc(record.color_word[15:8]);
        side_next[0].dc_b    = color_dc(record.color_word[23:16]);
        side_next[0].logit   = LOGIT_TAB[record.color_word[31:24]];
        side_next[0].scale_x = '0;
        side_next[0].scale_y = '0;
        side_next[0].scale_z = '0;
        for (int k = 1; k < NST; k++)
        begin
            side_next[k] = side_reg[k-1];
            if (k == SCALE_DONE)
            begin
                side_next[k].scale_x = lane_scale[0];
                side_next[k].scale_y = lane_scale[1];
                side_next[k].scale_z = lane_scale[2];
            end
        end
    end

    for (genvar k = 0; k < NST; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (load[k])
                side_reg[k] <= side_next[k];
        end
    end

    sad_scale_lane u_lane_x (
        .clk   (clk),
        .load  (load[3:0]),
        .code  (record.scale_code_x),
        .lo    (scale_min_reg),
        .hi    (scale_max_reg),
        .scale (lane_scale[0])
    );

    sad_scale_lane u_lane_y (
        .clk   (clk),
        .load  (load[3:0]),
        .code  (record.scale_code_y),
        .lo    (scale_min_reg),
        .hi    (scale_max_reg),
        .scale (lane_scale[1])
    );

    sad_scale_lane u_lane_z (
        .clk   (clk),
        .load  (load[3:0]),
        .code  (record.scale_code_z),
        .lo    (scale_min_reg),
        .hi    (scale_max_reg),
        .scale (lane_scale[2])
    );

    // quaternion: unpack and square
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            v0_next[i]  = 11'($signed({1'b0, record.rotation_word[10*i +: 10], 1'b0})
                        - 12'sd1023);
            sq0_next[i] = 20'(v0_next[i] * v0_next[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            v0_reg    <= v0_next;
            sq0_reg   <= sq0_next;
            mode0_reg <= record.rotation_word[31:30];
        end
    end

    // quaternion: fourth component and search seed
    always_comb
    begin
        s1   = 22'(sq0_reg[0]) + 22'(sq0_reg[1]) + 22'(sq0_reg[2]);
        w2_1 = (s1 < QUAT_R2) ? QUAT_R2 - s1 : 22'd0;
        l2_1 = s1 + w2_1;
        root1_next.l2   = l2_1;
        root1_next.mode = mode0_reg;
        for (int i = 0; i < 4; i++)
        begin
            root1_next.comp[i].neg = (i < 3) ? v0_reg[i % 3][10] : 1'b0;
            root1_next.comp[i].p   = (i < 3) ? 22'(sq0_reg[i % 3]) : w2_1;
            root1_next.comp[i].m   = '0;
            root1_next.comp[i].a   = $signed({36'd0, l2_1});
            root1_next.comp[i].b   = -$signed({36'd0, l2_1});
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
            root1_reg <= root1_next;
    end

    for (genvar j = 0; j < MAG_BITS; j++)
    begin : g_root
        sad_root_step #(
            .BIT (MAG_BITS - 1 - j)
        ) u_step (
            .clk      (clk),
            .load     (load[j+2]),
            .root_in  ((j == 0) ? root1_reg : root_pipe[(j == 0) ? 0 : j - 1]),
            .root_out (root_pipe[j])
        );
    end

    // quaternion: placement and sign
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sel_out[i]   = QUAT_PLACE[root_pipe[MAG_BITS-1].mode][i];
            mag_out[i]   = $signed({1'b0, root_pipe[MAG_BITS-1].comp[sel_out[i]].m});
            quat_next[i] = root_pipe[MAG_BITS-1].comp[sel_out[i]].neg ? -mag_out[i]
                                                                       : mag_out[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[NST-1])
            quat_reg <= quat_next;
    end

    assign result.valid         = vld_reg[NST-1];
    assign result.dc_red        = side_reg[NST-1].dc_r;
    assign result.dc_green      = side_reg[NST-1].dc_g;
    assign result.dc_blue       = side_reg[NST-1].dc_b;
    assign result.opacity_logit = side_reg[NST-1].logit;
    assign result.scale_out_x   = side_reg[NST-1].scale_x;
    assign result.scale_out_y   = side_reg[NST-1].scale_y;
    assign result.scale_out_z   = side_reg[NST-1].scale_z;
    assign result.quat_first    = quat_reg[0];
    assign result.quat_second   = quat_reg[1];
    assign result.quat_third    = quat_reg[2];
    assign result.quat_fourth   = quat_reg[3];

    `SAD_ASSERT_IMP(a_bubble_takes_record, !vld_reg[0], record.ready, "empty first stage refused a record")
    `SAD_ASSERT_NXT(a_last_stage_fills, load[NST-1], result.valid, "last stage load lost its transaction")
    `SAD_ASSERT_IMP(a_quat_unit_range, result.valid, (result.quat_first <= 16'sd16384) && (result.quat_first >= -16'sd16384), "quaternion component out of unit range")
    `SAD_ASSERT_IMP(a_logit_range, result.valid, (result.opacity_logit <= LOGIT_CLAMP) && (result.opacity_logit >= -LOGIT_CLAMP), "opacity logit beyond clamp")

endmodule

>>> bench/tb_splat_attribute_decoder_core.sv
// testbench of the splat attribute decoder: predicted results checked in order under random flow control
`timescale 1ns / 100ps
module tb_splat_attribute_decoder_core;
    import sad_pkg::*;

    typedef struct {
        logic signed [15:0] dc [3];
        logic signed [15:0] logit;
        logic signed [31:0] scale [3];
        logic signed [15:0] quat [4];
    } decoded_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_idx_t cfg_index;
    logic [31:0] cfg_data;
    int error_count;
    bit no_idle;
    bit hold_req;
    logic signed [31:0] cur_min;
    logic signed [31:0] cur_max;

    sad_rec_if record ();
    sad_res_if result ();

    splat_attribute_decoder_core uut (
        .clk(clk), .rst_n(rst_n), .record(record.sink), .result(result.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic logic signed [15:0] dc_of(input logic [7:0] c);
        int d;
        longint m;
        longint r;
        d = 2 * int'(c) - 255;
        m = d < 0 ? -d : d;
        r = (m * 1865841 + 32768) >>> 16;
        return d < 0 ? 16'(-r) : 16'(r);
    endfunction

    function automatic logic [31:0] log2_fix(input int n);
        int k;
        logic [63:0] x;
        logic [23:0] frac;
        k = 0;
        frac = 0;
        while (k < 7 && (n >> (k + 1)) != 0)
            k++;
        x = 64'(n) << (30 - k);
        for (int i = 0; i < 24; i++)
        begin
            x = (x * x) >> 30;
            frac = {frac[22:0], 1'b0};
            if (x >= 64'h8000_0000)
            begin
                x = x >> 1;
                frac[0] = 1'b1;
            end
        end
        return {5'd0, 3'(k), frac};
    endfunction

    function automatic logic signed [15:0] logit_of(input logic [7:0] a);
        logic [31:0] la;
        logic [31:0] lb;
        logic [63:0] mag;
        logic [63:0] r;
        if (a == 0)
            return -16'sd28290;
        if (a == 255)
            return 16'sd28290;
        la = log2_fix(a);
        lb = log2_fix(255 - a);
        mag = la < lb ? lb - la : la - lb;
        r = (mag * 64'd744261118 + (64'd1 << 41)) >> 42;
        return la < lb ? 16'(-r) : 16'(r);
    endfunction

    function automatic logic signed [31:0] scale_of(input logic [15:0] code);
        longint prod;
        longint q;
        longint r;
        prod = longint'(code) * (longint'(cur_max) - longint'(cur_min));
        q = ((prod < 0 ? -prod : prod) + 32767) / 65535;
        r = longint'(cur_min) + (prod < 0 ? -q : q);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return 32'(r);
    endfunction

    function automatic int root_mag(input longint p, input longint l2);
        longint lo;
        longint hi;
        longint mid;
        longint t;
        lo = 0;
        hi = 16384;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            t = 2 * mid - 1;
            if (t * t * l2 <= (p << 30))
                lo = mid;
            else
                hi = mid - 1;
        end
        return int'(lo);
    endfunction

    class decode_scoreboard;
        decoded_t pending [$];

        function void note_record(logic [31:0] color, logic [15:0] cx, logic [15:0] cy,
                                  logic [15:0] cz, logic [31:0] rot);
            decoded_t e;
            int v [4];
            longint sq [4];
            longint s;
            int c;
            int m;
            for (int i = 0; i < 3; i++)
                e.dc[i] = dc_of(color[8*i +: 8]);
            e.logit = logit_of(color[31:24]);
            e.scale[0] = scale_of(cx);
            e.scale[1] = scale_of(cy);
            e.scale[2] = scale_of(cz);
            s = 0;
            for (int i = 0; i < 3; i++)
            begin
                v[i] = 2 * int'(rot[10*i +: 10]) - 1023;
                sq[i] = longint'(v[i]) * v[i];
                s += sq[i];
            end
            v[3] = 0;
            sq[3] = s < 2093058 ? 2093058 - s : 0;
            for (int i = 0; i < 4; i++)
            begin
                c = QUAT_PLACE[rot[31:30]][i];
                m = root_mag(sq[c], s + sq[3]);
                e.quat[i] = v[c] < 0 ? 16'(-m) : 16'(m);
            end
            pending.insert(pending.size(), e);
        endfunction

        task check_result(decoded_t got);
            decoded_t e;
            if (pending.size() == 0)
            begin
                report("unexpected transaction", 0, 0);
                return;
            end
            e = pending.pop_front();
            for (int i = 0; i < 3; i++)
            begin
                if (got.dc[i] !== e.dc[i]) report($sformatf("dc[%0d]", i), got.dc[i], e.dc[i]);
                if (got.scale[i] !== e.scale[i])
                    report($sformatf("scale[%0d]", i), got.scale[i], e.scale[i]);
            end
            if (got.logit !== e.logit) report("opacity_logit", got.logit, e.logit);
            for (int i = 0; i < 4; i++)
                if (got.quat[i] !== e.quat[i])
                    report($sformatf("quat[%0d]", i), got.quat[i], e.quat[i]);
        endtask
    endclass

    decode_scoreboard board;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && record.valid && record.ready)
            board.note_record(record.color_word, record.scale_code_x, record.scale_code_y,
                              record.scale_code_z, record.rotation_word);
    end

    always @(posedge clk)
    begin
        decoded_t got;
        if (rst_n && result.valid && result.ready)
        begin
            got.dc[0] = result.dc_red;
            got.dc[1] = result.dc_green;
            got.dc[2] = result.dc_blue;
            got.logit = result.opacity_logit;
            got.scale[0] = result.scale_out_x;
            got.scale[1] = result.scale_out_y;
            got.scale[2] = result.scale_out_z;
            got.quat[0] = result.quat_first;
            got.quat[1] = result.quat_second;
            got.quat[2] = result.quat_third;
            got.quat[3] = result.quat_fourth;
            board.check_result(got);
        end
    end

    // receiver flow control
    initial
    begin
        int n;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                result.ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 10);
                result.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                n = $urandom_range(1, 20);
                result.ready <= 1'b1;
                repeat (n) @(posedge clk);
            end
        end
    end

    task automatic send_record(input logic [31:0] color, input logic [15:0] cx,
                               input logic [15:0] cy, input logic [15:0] cz,
                               input logic [31:0] rot);
        if (!no_idle && $urandom_range(0, 4) == 0)
        begin
            record.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        record.valid <= 1'b1;
        record.color_word <= color;
        record.scale_code_x <= cx;
        record.scale_code_y <= cy;
        record.scale_code_z <= cz;
        record.rotation_word <= rot;
        do
            @(posedge clk);
        while (!record.ready);
    endtask

    task automatic send_random();
        logic [31:0] rot;
        rot = $urandom;
        if ($urandom_range(0, 5) == 0)
            rot[29:0] = {($urandom_range(0, 1) ? 10'h3FF : 10'h0),
                         ($urandom_range(0, 1) ? 10'h3FF : 10'h0), 10'($urandom)};
        send_record($urandom, 16'($urandom), 16'($urandom), 16'($urandom), rot);
    endtask

    task automatic drain_and_write(input logic signed [31:0] lo, input logic signed [31:0] hi);
        record.valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_SCALE_MIN;
        cfg_data <= lo;
        @(posedge clk);
        cfg_index <= REG_SCALE_MAX;
        cfg_data <= hi;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_min = lo;
        cur_max = hi;
    endtask

    initial
    begin
        logic signed [31:0] lo_set [5];
        logic signed [31:0] hi_set [5];
        board = new();
        error_count = 0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        cur_min = 32'sd168;
        cur_max = 32'sd83886080;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_SCALE_MIN;
        cfg_data = '0;
        record.valid = 1'b0;
        record.color_word = '0;
        record.scale_code_x = '0;
        record.scale_code_y = '0;
        record.scale_code_z = '0;
        record.rotation_word = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values, directed records
        send_record(32'h00000000, 16'd0, 16'd65535, 16'd32768, 32'h00000000);
        send_record(32'hFFFFFFFF, 16'd65535, 16'd0, 16'd1, 32'hFFFFFFFF);
        send_record(32'h01807F80, 16'd32767, 16'd32768, 16'd65534, 32'h3FFFFFFF);
        send_record(32'hFE7F807F, 16'd1, 16'd2, 16'd3, 32'h7FF00000);
        send_record(32'h80FF00FF, 16'd100, 16'd200, 16'd300, 32'h8007FDFF);
        send_record(32'h7F00FF00, 16'd65535, 16'd65535, 16'd65535, 32'hC0080200);
        for (int mode = 0; mode < 4; mode++)
        begin
            send_record($urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                        {2'(mode), 10'd511, 10'd700, 10'd300});
            send_record($urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                        {2'(mode), 10'd1023, 10'd0, 10'd1023});
            send_record($urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                        {2'(mode), 10'd512, 10'd512, 10'd511});
        end

        hold_req = 1'b1;
        repeat (60) send_random();

        lo_set = '{32'h80000000, 32'h7FFFFFFF, 32'sd1000, 32'h00000000, 32'h00000000};
        hi_set = '{32'h7FFFFFFF, 32'h80000000, 32'sd1000, 32'h00000000, 32'h00000000};
        lo_set[3] = $urandom;
        hi_set[3] = $urandom;
        lo_set[4] = 32'sd168;
        hi_set[4] = 32'sd83886080;
        for (int ph = 0; ph < 5; ph++)
        begin
            drain_and_write(lo_set[ph], hi_set[ph]);
            send_record(32'h00000000, 16'd0, 16'd65535, 16'd32768, 32'hFFFFFFFF);
            if (ph == 4)
                no_idle = 1'b1;
            repeat (ph == 4 ? 100 : 65) send_random();
        end

        record.valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/sad_pkg.sv
hw/rtl/sad_if.sv
hw/rtl/sad_scale_lane.sv
hw/rtl/sad_root_step.sv
hw/rtl/splat_attribute_decoder_core.sv
bench/tb_splat_attribute_decoder_core.sv
